// ----- rtl/pas_pkg.sv -----
// shared types and constants for the priority access scheduler
`timescale 1ns / 1ps
`default_nettype none

package pas_pkg;

   // default sizing of the scheduler
   localparam int DEF_AGENTS        = 16;
   localparam int DEF_PRIORITY_BITS = 16;

   // fixed field widths of the request and response channels
   localparam int OP_W        = 2;
   localparam int ID_W        = 4;
   localparam int NEW_PRIO_W  = 16;
   localparam int AGENT_OUT_W = 4;
   localparam int COUNT_W     = 5;
   localparam int WAIT_MAX    = (2 ** COUNT_W) - 1;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_REQUEST  = 2'd0,
      OP_RELEASE  = 2'd1,
      OP_SET_PRIO = 2'd2,
      OP_SCHEDULE = 2'd3
   } op_type;

   // sequencer states, one-hot
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/pas_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module pas_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/priority_access_scheduler.sv -----
// top level of the priority access scheduler
//
// Exclusive-access scheduler. Each request carries an operation, an agent id
// and a priority. Request, release and set priority update the pending set,
// the age ranks or the priority store, and the response is presented on the
// cycle after the request is accepted; these requests can be accepted on
// every cycle while the response side keeps up.
// A schedule request that can grant walks all AGENTS entries of the priority
// ram, one per cycle, through one shared compare unit that keeps the best
// candidate (higher priority wins, equal priority goes to the older request).
// The response is loaded once the last entry has been compared, and no new
// request is taken until the walk has ended; the entries are read one at a
// time through the single ram read port.
// A schedule request that cannot grant answers on the cycle after acceptance.
// Both channels use valid and stall. The response register is a stage of its
// own: a new request is taken while the response is still held, unless the
// response is stalled. req_stall is high during a walk.
// Reset (synchronous) clears the pending set, the grant holder and the valid
// bits of the priority store, so every priority reads zero until written.
`timescale 1ns / 1ps
`default_nettype none

module priority_access_scheduler #(
   parameter int AGENTS        = pas_pkg::DEF_AGENTS,
   parameter int PRIORITY_BITS = pas_pkg::DEF_PRIORITY_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic [pas_pkg::OP_W-1:0]               req_operation,
   input  wire logic [pas_pkg::ID_W-1:0]               req_agent_id,
   input  wire logic signed [pas_pkg::NEW_PRIO_W-1:0]  req_new_priority,
   // response channel
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic                                   rsp_granted,
   output      logic [pas_pkg::AGENT_OUT_W-1:0]        rsp_granted_agent,
   output      logic                                   rsp_busy_res,
   output      logic [pas_pkg::AGENT_OUT_W-1:0]        rsp_holder_agent,
   output      logic [pas_pkg::COUNT_W-1:0]            rsp_waiting_count
);

   localparam int AGENT_W = $clog2(AGENTS);
   localparam int CNT_W   = $clog2(AGENTS + 1);
   localparam int IDX_W   = (AGENT_W > pas_pkg::AGENT_OUT_W) ? AGENT_W : pas_pkg::AGENT_OUT_W;
   localparam logic signed [63:0] PRIO_MAX = (64'sd1 <<< (PRIORITY_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] PRIO_MIN = -PRIO_MAX - 64'sd1;

   // sequencer and scheduler state
   pas_pkg::state_type state_ff, state_in;
   logic [AGENTS-1:0]  pend_ff, pend_in;
   logic [CNT_W-1:0]   pend_cnt_ff, pend_cnt_in;
   logic [AGENT_W-1:0] rank_ff [AGENTS];
   logic [AGENT_W-1:0] rank_in [AGENTS];
   logic [AGENTS-1:0]  prio_vld_ff, prio_vld_in;
   logic               hold_vld_ff, hold_vld_in;
   logic [AGENT_W-1:0] hold_idx_ff, hold_idx_in;

   // walk counters and best candidate
   logic [CNT_W-1:0]           scan_idx_ff, scan_idx_in;
   logic                       cmp_vld_ff, cmp_vld_in;
   logic [AGENT_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                       best_have_ff, best_have_in;
   logic [AGENT_W-1:0]         best_idx_ff, best_idx_in;
   logic signed [PRIORITY_BITS-1:0] best_prio_ff, best_prio_in;
   logic [AGENT_W-1:0]         best_rank_ff, best_rank_in;

   // response register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_granted_ff, rsp_granted_in;
   logic [pas_pkg::AGENT_OUT_W-1:0] rsp_gagent_ff, rsp_gagent_in;
   logic                            rsp_busy_ff, rsp_busy_in;
   logic [pas_pkg::AGENT_OUT_W-1:0] rsp_holder_ff, rsp_holder_in;
   logic [pas_pkg::COUNT_W-1:0]     rsp_wait_ff, rsp_wait_in;
   logic                            load_rsp;

   // request decode
   logic                      req_take;
   pas_pkg::op_type           op;
   logic                      id_ok;
   logic [IDX_W-1:0]          id_wide;
   logic [AGENT_W-1:0]        agent_idx;
   logic signed [63:0]        np_ext;
   logic signed [63:0]        np_sat;
   logic [PRIORITY_BITS-1:0]  prio_wr;

   // priority ram
   logic                      ram_wr_en;
   logic                      ram_rd_en;
   logic [PRIORITY_BITS-1:0]  ram_rd_data;

   // shared compare unit
   logic signed [PRIORITY_BITS-1:0] cand_prio;
   logic [AGENT_W-1:0]              cand_rank;
   logic                            cand_take;
   logic [AGENT_W-1:0]              win_idx;
   logic                            scan_done;

   // drop of an agent from the pending set
   logic               drop_en;
   logic [AGENT_W-1:0] drop_idx;
   logic [AGENT_W-1:0] drop_rank;

   // narrowing of agent indices to the response width
   logic               granted_now;
   logic [IDX_W-1:0]   win_wide;
   logic [IDX_W-1:0]   hold_wide;

   assign req_stall = (state_ff != pas_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign op        = pas_pkg::op_type'(req_operation);
   assign id_wide   = IDX_W'(req_agent_id);
   assign agent_idx = id_wide[AGENT_W-1:0];
   assign id_ok     = (32'(req_agent_id) < AGENTS);

   // saturate the incoming priority to the stored width
   assign np_ext  = 64'(req_new_priority);
   assign np_sat  = (np_ext > PRIO_MAX) ? PRIO_MAX : ((np_ext < PRIO_MIN) ? PRIO_MIN : np_ext);
   assign prio_wr = np_sat[PRIORITY_BITS-1:0];

   pas_ram #(
      .WIDTH (PRIORITY_BITS),
      .DEPTH (AGENTS)
   ) u_prio_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (agent_idx),
      .wr_data (prio_wr),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff[AGENT_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // compare the candidate read last cycle against the best so far
   assign cand_prio = prio_vld_ff[cmp_idx_ff] ? signed'(ram_rd_data) : '0;
   assign cand_rank = rank_ff[cmp_idx_ff];
   assign cand_take = cmp_vld_ff && pend_ff[cmp_idx_ff] &&
                      (!best_have_ff || (cand_prio > best_prio_ff) ||
                       ((cand_prio == best_prio_ff) && (cand_rank < best_rank_ff)));
   assign win_idx   = cand_take ? cmp_idx_ff : best_idx_ff;
   assign scan_done = (state_ff == pas_pkg::ST_SCAN) && cmp_vld_ff &&
                      (cmp_idx_ff == AGENT_W'(AGENTS - 1));

   // sequencer and state update
   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      pend_cnt_in  = pend_cnt_ff;
      rank_in      = rank_ff;
      prio_vld_in  = prio_vld_ff;
      hold_vld_in  = hold_vld_ff;
      hold_idx_in  = hold_idx_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_have_in = best_have_ff;
      best_idx_in  = best_idx_ff;
      best_prio_in = best_prio_ff;
      best_rank_in = best_rank_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      drop_en      = 1'b0;
      drop_idx     = '0;
      load_rsp     = 1'b0;
      granted_now  = 1'b0;

      unique case (state_ff)
         pas_pkg::ST_IDLE: begin
            if (req_take) begin
               unique case (op)
                  pas_pkg::OP_REQUEST: begin
                     load_rsp = 1'b1;
                     if (id_ok) begin
                        // a new waiter becomes the youngest
                        if (!pend_ff[agent_idx]) begin
                           pend_in[agent_idx] = 1'b1;
                           rank_in[agent_idx] = AGENT_W'(pend_cnt_ff);
                           pend_cnt_in        = pend_cnt_ff + 1'b1;
                        end
                        if (hold_vld_ff && (hold_idx_ff == agent_idx)) begin
                           hold_vld_in = 1'b0;
                           hold_idx_in = '0;
                        end
                     end
                  end
                  pas_pkg::OP_RELEASE: begin
                     load_rsp = 1'b1;
                     if (id_ok) begin
                        if (pend_ff[agent_idx]) begin
                           drop_en  = 1'b1;
                           drop_idx = agent_idx;
                        end
                        if (hold_vld_ff && (hold_idx_ff == agent_idx)) begin
                           hold_vld_in = 1'b0;
                           hold_idx_in = '0;
                        end
                     end
                  end
                  pas_pkg::OP_SET_PRIO: begin
                     load_rsp = 1'b1;
                     if (id_ok) begin
                        ram_wr_en              = 1'b1;
                        prio_vld_in[agent_idx] = 1'b1;
                     end
                  end
                  pas_pkg::OP_SCHEDULE: begin
                     if (!hold_vld_ff && (pend_cnt_ff != '0)) begin
                        state_in     = pas_pkg::ST_SCAN;
                        scan_idx_in  = '0;
                        cmp_vld_in   = 1'b0;
                        best_have_in = 1'b0;
                     end else begin
                        load_rsp = 1'b1;
                     end
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         pas_pkg::ST_SCAN: begin
            // issue the next priority read
            if (32'(scan_idx_ff) < AGENTS) begin
               ram_rd_en   = 1'b1;
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_idx_ff[AGENT_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end else begin
               cmp_vld_in = 1'b0;
            end
            // keep the best candidate
            if (cand_take) begin
               best_have_in = 1'b1;
               best_idx_in  = cmp_idx_ff;
               best_prio_in = cand_prio;
               best_rank_in = cand_rank;
            end
            // grant the winner once the last agent is compared
            if (scan_done) begin
               drop_en     = 1'b1;
               drop_idx    = win_idx;
               hold_vld_in = 1'b1;
               hold_idx_in = win_idx;
               granted_now = 1'b1;
               load_rsp    = 1'b1;
               cmp_vld_in  = 1'b0;
               state_in    = pas_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pas_pkg::ST_IDLE;
         end
      endcase

      // remove an agent and close the gap in the age ranks
      drop_rank = rank_ff[drop_idx];
      if (drop_en) begin
         for (int j = 0; j < AGENTS; j++) begin
            if (pend_ff[j] && (rank_ff[j] > drop_rank)) begin
               rank_in[j] = rank_ff[j] - 1'b1;
            end
         end
         pend_in[drop_idx] = 1'b0;
         pend_cnt_in       = pend_cnt_ff - 1'b1;
      end
   end

   // response contents, taken from the state after the request
   assign win_wide  = IDX_W'(win_idx);
   assign hold_wide = IDX_W'(hold_idx_in);

   always_comb begin
      rsp_granted_in = granted_now;
      rsp_gagent_in  = granted_now ? win_wide[pas_pkg::AGENT_OUT_W-1:0] : '0;
      rsp_busy_in    = hold_vld_in;
      rsp_holder_in  = hold_vld_in ? hold_wide[pas_pkg::AGENT_OUT_W-1:0] : '0;
      rsp_wait_in    = (32'(pend_cnt_in) > pas_pkg::WAIT_MAX) ?
                       pas_pkg::COUNT_W'(pas_pkg::WAIT_MAX) : pas_pkg::COUNT_W'(pend_cnt_in);
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pas_pkg::ST_IDLE;
         pend_ff      <= '0;
         pend_cnt_ff  <= '0;
         prio_vld_ff  <= '0;
         hold_vld_ff  <= 1'b0;
         hold_idx_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         best_have_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         pend_cnt_ff  <= pend_cnt_in;
         prio_vld_ff  <= prio_vld_in;
         hold_vld_ff  <= hold_vld_in;
         hold_idx_ff  <= hold_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         best_have_ff <= best_have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rank_ff      <= rank_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_prio_ff <= best_prio_in;
      best_rank_ff <= best_rank_in;
      if (load_rsp) begin
         rsp_granted_ff <= rsp_granted_in;
         rsp_gagent_ff  <= rsp_gagent_in;
         rsp_busy_ff    <= rsp_busy_in;
         rsp_holder_ff  <= rsp_holder_in;
         rsp_wait_ff    <= rsp_wait_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_granted_agent = rsp_gagent_ff;
   assign rsp_busy_res      = rsp_busy_ff;
   assign rsp_holder_agent  = rsp_holder_ff;
   assign rsp_waiting_count = rsp_wait_ff;

   // the grant holder is never also waiting
   assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> !pend_ff[hold_idx_ff])
      else $error("grant holder still marked pending");

   // the waiting count tracks the pending set
   assert property (@(posedge clock) disable iff (reset)
      32'(pend_cnt_ff) == $countones(pend_ff))
      else $error("pending count out of step with pending set");

   // a granting response reports the new holder as busy
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_granted_ff) |-> (rsp_busy_ff && (rsp_holder_ff == rsp_gagent_ff)))
      else $error("grant response does not show the granted agent as holder");

   // a walk is only started when no grant is held
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pas_pkg::ST_SCAN) |-> !hold_vld_ff)
      else $error("schedule walk running while grant is held");

endmodule

`default_nettype wire
